[sv/sme_pkg.sv]
// Package for the stack machine execute block: opcodes, status codes, state encoding.
// Used by sme_iter, stack_machine_execute and the testbench; depends on nothing.
package sme_pkg;

    typedef enum logic [4:0] {
        OP_HALT = 5'd0, OP_PUSH = 5'd1, OP_POP = 5'd2, OP_IN = 5'd3, OP_OUT = 5'd4,
        OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_SQRT = 5'd9,
        OP_SQR = 5'd10, OP_CALL = 5'd11, OP_RET = 5'd12, OP_JMP = 5'd13, OP_JA = 5'd14,
        OP_JAE = 5'd15, OP_JB = 5'd16, OP_JBE = 5'd17, OP_JE = 5'd18, OP_JNE = 5'd19
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_HALTED = 3'd1, ST_END = 3'd2, ST_ILLEGAL = 3'd3,
        ST_STACK = 3'd4, ST_DIVZERO = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_ITER, S_FINISH, S_OUT
    } state_t;

    localparam int REG_PROGRAM_LENGTH = 0;
    localparam int REG_SCALE = 1;
    localparam int REG_OPCODE_BYTES = 2;
    localparam int REG_VALUE_BYTES = 3;

    // Request to the iterative arithmetic unit.
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] numer;
        logic [31:0] denom;
    } iter_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } iter_rsp_t;

endpackage

[sv/sme_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/sme_iter.sv]
// Iterative unit: signed 64/32 division truncating toward zero, or a 64-bit integer
// square root, one result bit per cycle. Depends on sme_pkg.
module sme_iter (
    input  logic               clk,
    input  logic               rst_n,
    input  sme_pkg::iter_req_t req,
    output sme_pkg::iter_rsp_t rsp
);
    import sme_pkg::*;

    logic        busy_reg;
    logic        busy_next;
    logic        div_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic [63:0] num_reg;
    logic [63:0] num_next;
    logic [65:0] rem_reg;
    logic [65:0] rem_next;
    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [32:0] den_reg;
    logic [65:0] trial;
    logic [65:0] diff;
    logic [63:0] num_abs;
    logic [32:0] den_abs;

    assign num_abs = req.numer[63] ? (64'd0 - req.numer) : req.numer;
    assign den_abs = req.denom[31] ? (33'd0 - {1'b1, req.denom}) : {1'b0, req.denom};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial = '0;
        diff = '0;
        if (busy_reg)
        begin
            if (div_reg)
            begin
                trial = {rem_reg[64:0], num_reg[63]};
                diff = trial - {33'd0, den_reg};
                num_next = {num_reg[62:0], 1'b0};
                if (!diff[65])
                begin
                    rem_next = diff;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
            end
            else
            begin
                trial = {rem_reg[63:0], num_reg[63:62]};
                diff = trial - {quo_reg, 2'b01};
                num_next = {num_reg[61:0], 2'b00};
                if (!diff[65])
                begin
                    rem_next = diff;
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd2;
            end
            if ((div_reg && cnt_reg == 7'd1) || (!div_reg && cnt_reg == 7'd2))
            begin
                busy_next = 1'b0;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = 7'd64;
            rem_next = '0;
            quo_next = '0;
            num_next = req.is_div ? num_abs : req.numer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (!busy_reg && req.start)
        begin
            div_reg <= req.is_div;
            den_reg <= den_abs;
            neg_reg <= req.numer[63] ^ req.denom[31];
        end
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && !busy_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.result = (div_reg && neg_reg) ? (64'd0 - quo_reg) : quo_reg;
endmodule

[sv/stack_machine_execute.sv]
// Top level of the fixed-point stack processor execute block: control sequencer,
// register file and the stack/memory RAMs. Depends on sme_pkg, sme_ram, sme_iter.
//
//  channel  | dir | handshake        | payload
//  s_axis   | in  | tvalid/tready    | tdata: kind, flags, immediate, register, target, console
//  m_axis   | out | tvalid/tready    | tdata: status, next_ip, out_valid, out_value
//  apb      | in  | psel/penable     | four configuration registers at 4*i
//
// An instruction passes through accept, stack read and multiply, execute, write back and
// result; sqrt, div, mul and sqr also run through the iterative unit after execute.
// After reset the data memory is cleared by a sweep over its MEMORY_WORDS words during
// which no word is accepted. Results wait in the output register until taken.
module stack_machine_execute #(
    parameter int DATA_STACK_DEPTH = 64,
    parameter int RETURN_STACK_DEPTH = 16,
    parameter int MEMORY_WORDS = 1024,
    parameter int REGISTER_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[4:0], use_immediate[5], use_register[6], use_memory[7], immediate[39:8],
    // register_index[41:40], target_address[57:42], console_value[89:58], zero fill
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], next_ip[18:3], out_valid[19], out_value[51:20], zero fill
    output logic [55:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sme_pkg::*;

    localparam int DAW = $clog2(DATA_STACK_DEPTH);
    localparam int RAW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
    localparam int RSD = (RETURN_STACK_DEPTH > 1) ? RETURN_STACK_DEPTH : 2;
    localparam int MAW = $clog2(MEMORY_WORDS);
    localparam int GRW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    // Configuration.
    logic [15:0] plen_reg;
    logic [9:0]  scale_reg;
    logic [3:0]  obytes_reg;
    logic [3:0]  vbytes_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= 16'hFFFF;
            scale_reg <= 10'd100;
            obytes_reg <= 4'd1;
            vbytes_reg <= 4'd4;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                2'(REG_PROGRAM_LENGTH): plen_reg <= pwdata[15:0];
                2'(REG_SCALE):          scale_reg <= pwdata[9:0];
                2'(REG_OPCODE_BYTES):   obytes_reg <= pwdata[3:0];
                2'(REG_VALUE_BYTES):    vbytes_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            2'(REG_PROGRAM_LENGTH): prdata = {16'd0, plen_reg};
            2'(REG_SCALE):          prdata = {22'd0, scale_reg};
            2'(REG_OPCODE_BYTES):   prdata = {28'd0, obytes_reg};
            default:                prdata = {28'd0, vbytes_reg};
        endcase
    end

    // Latched instruction.
    logic [4:0]  kind_reg;
    logic        ui_reg, ur_reg, um_reg;
    logic [31:0] imm_reg;
    logic [GRW-1:0] ri_reg;
    logic [15:0] tgt_reg;
    logic [31:0] con_reg;

    // Architectural control state.
    state_t      state_reg, state_next;
    logic [15:0] ip_reg;
    logic [DAW:0] dcnt_reg;
    logic [RAW:0] rcnt_reg;
    logic        stopped_reg;
    logic [31:0] gr_reg [REGISTER_COUNT];
    logic [MAW:0] clr_reg;
    logic        clearing;
    assign clearing = !clr_reg[MAW];

    // Operand registers.
    logic [31:0] top_reg, below_reg;
    logic [63:0] acc_reg;
    logic [2:0]  st_reg;
    logic [15:0] nip_reg;
    logic        ovld_reg;
    logic [31:0] oval_reg;

    // Memories.
    logic           ds_we;
    logic [DAW-1:0] ds_waddr, ds_raddr, ds_raddr2;
    logic [31:0]    ds_wdata, ds_rdata, ds_rdata2;
    logic           rs_we;
    logic [RAW-1:0] rs_waddr, rs_raddr;
    logic [15:0]    rs_wdata, rs_rdata;
    logic           dm_we;
    logic [MAW-1:0] dm_waddr, dm_raddr;
    logic [31:0]    dm_wdata, dm_rdata;

    sme_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_dstack_top (
        .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr), .rdata(ds_rdata));
    sme_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_dstack_below (
        .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
        .raddr(ds_raddr2), .rdata(ds_rdata2));
    sme_ram #(.WIDTH(16), .DEPTH(RSD)) u_rstack (
        .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
        .raddr(rs_raddr), .rdata(rs_rdata));
    sme_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_dmem (
        .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_rdata));

    iter_req_t ireq;
    iter_rsp_t irsp;
    sme_iter u_iter (.clk(clk), .rst_n(rst_n), .req(ireq), .rsp(irsp));

    // Decode helpers on latched instruction.
    logic [31:0] regv, immv, addr_sum;
    logic [15:0] seq_ip;
    logic [15:0] nip_calc;
    logic [9:0]  sc;
    assign sc = (scale_reg == 10'd0) ? 10'd1 : scale_reg;
    assign regv = ur_reg ? gr_reg[ri_reg] : 32'd0;
    assign immv = ui_reg ? imm_reg : 32'd0;
    assign addr_sum = immv + regv;
    assign seq_ip = ip_reg + 16'(obytes_reg) + (ui_reg ? 16'(vbytes_reg) : 16'd0)
                    + (ur_reg ? 16'(obytes_reg) : 16'd0);

    logic [15:0] in_ip;
    assign in_ip = ip_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !clearing;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {4'd0, oval_reg, ovld_reg, nip_reg, st_reg};

    assign ds_raddr  = DAW'(dcnt_reg - 1'b1);
    assign ds_raddr2 = DAW'(dcnt_reg - 2'd2);
    assign rs_raddr  = RAW'(rcnt_reg - 1'b1);
    assign dm_raddr  = MAW'(addr_sum);

    logic signed [63:0] prod;
    logic signed [31:0] top_s, below_s;
    assign top_s = top_reg;
    assign below_s = below_reg;

    logic is_stack_fault, is_illegal, take;
    always_comb
    begin
        is_illegal = 1'b0;
        is_stack_fault = 1'b0;
        take = 1'b0;
        case (kind_reg)
            OP_PUSH, OP_IN: is_stack_fault = dcnt_reg >= (DAW+1)'(DATA_STACK_DEPTH);
            OP_POP:
            begin
                is_illegal = (ui_reg && ur_reg) || (ui_reg && !um_reg);
                is_stack_fault = dcnt_reg == '0;
            end
            OP_OUT, OP_SQRT, OP_SQR: is_stack_fault = dcnt_reg == '0;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE:
                is_stack_fault = dcnt_reg < (DAW+1)'(2);
            OP_CALL: is_stack_fault = rcnt_reg >= (RAW+1)'(RETURN_STACK_DEPTH);
            OP_RET:  is_stack_fault = rcnt_reg == '0;
            OP_HALT, OP_JMP: ;
            default: is_illegal = 1'b1;
        endcase
        case (kind_reg)
            OP_JA:  take = top_s > below_s;
            OP_JAE: take = top_s >= below_s;
            OP_JB:  take = top_s < below_s;
            OP_JBE: take = top_s <= below_s;
            OP_JE:  take = top_s == below_s;
            default: take = top_s != below_s;
        endcase
    end

    // One multiply per cycle; registered before use.
    logic signed [31:0] rd_top, rd_below, mul_a, mul_b;
    assign rd_top = ds_rdata;
    assign rd_below = ds_rdata2;
    always_comb
    begin
        case (kind_reg)
            OP_IN:   begin mul_a = con_reg; mul_b = {22'd0, sc}; end
            OP_PUSH: begin mul_a = immv; mul_b = {22'd0, sc}; end
            OP_MUL:  begin mul_a = rd_top; mul_b = rd_below; end
            OP_DIV:  begin mul_a = rd_below; mul_b = {22'd0, sc}; end
            OP_SQRT: begin mul_a = rd_top; mul_b = {22'd0, sc}; end
            default: begin mul_a = rd_top; mul_b = rd_top; end
        endcase
        prod = mul_a * mul_b;
    end

    // Execute result.
    logic [31:0] result;
    always_comb
    begin
        case (kind_reg)
            OP_ADD:  result = below_reg + top_reg;
            OP_SUB:  result = below_reg - top_reg;
            OP_IN:   result = acc_reg[31:0];
            OP_PUSH: result = um_reg ? dm_rdata : acc_reg[31:0] + regv;
            OP_SQRT: result = top_s[31] ? 32'd0 : irsp.result[31:0];
            default: result = irsp.result[31:0];
        endcase
    end

    logic iter_op;
    assign iter_op = (kind_reg == OP_MUL) || (kind_reg == OP_DIV) ||
                     (kind_reg == OP_SQR) || (kind_reg == OP_SQRT);
    assign ireq.start = (state_reg == S_EXEC) && iter_op && !is_stack_fault &&
                        !(kind_reg == OP_DIV && top_reg == 32'd0);
    assign ireq.is_div = kind_reg != OP_SQRT;
    assign ireq.numer = acc_reg;
    assign ireq.denom = (kind_reg == OP_DIV) ? top_reg : {22'd0, sc};

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ds_we = 1'b0;
        ds_waddr = DAW'(dcnt_reg);
        ds_wdata = result;
        rs_we = 1'b0;
        rs_waddr = RAW'(rcnt_reg);
        rs_wdata = ip_reg + 16'(obytes_reg) + 16'(vbytes_reg);
        dm_we = 1'b0;
        dm_waddr = MAW'(addr_sum);
        dm_wdata = top_reg;
        if (clearing)
        begin
            dm_we = 1'b1;
            dm_waddr = clr_reg[MAW-1:0];
            dm_wdata = '0;
        end
        case (state_reg)
            S_IDLE:   if (s_axis_tvalid && !clearing) state_next = S_READ;
            S_READ:   state_next = S_EXEC;
            S_EXEC:   state_next = ireq.start ? S_ITER : S_FINISH;
            S_ITER:   if (irsp.done) state_next = S_FINISH;
            S_FINISH:
            begin
                state_next = S_OUT;
                if (!stopped_reg && ip_reg < plen_reg && !is_illegal && !is_stack_fault)
                begin
                    case (kind_reg)
                        OP_PUSH, OP_IN: ds_we = 1'b1;
                        OP_POP:
                        begin
                            dm_we = um_reg;
                        end
                        OP_ADD, OP_SUB, OP_MUL:
                        begin
                            ds_we = 1'b1;
                            ds_waddr = DAW'(dcnt_reg - 2'd2);
                        end
                        OP_DIV:
                        begin
                            ds_we = top_reg != 32'd0;
                            ds_waddr = DAW'(dcnt_reg - 2'd2);
                        end
                        OP_SQRT, OP_SQR:
                        begin
                            ds_we = 1'b1;
                            ds_waddr = DAW'(dcnt_reg - 1'b1);
                        end
                        OP_CALL: rs_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_OUT:    if (m_axis_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ip_reg <= '0;
            dcnt_reg <= '0;
            rcnt_reg <= '0;
            stopped_reg <= 1'b0;
            clr_reg <= '0;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                gr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == S_FINISH)
            begin
                if (stopped_reg)
                begin
                    ;
                end
                else if (ip_reg >= plen_reg)
                begin
                    stopped_reg <= 1'b1;
                end
                else if (!is_illegal && !is_stack_fault &&
                         !(kind_reg == OP_DIV && top_reg == 32'd0))
                begin
                    case (kind_reg)
                        OP_HALT: stopped_reg <= 1'b1;
                        OP_PUSH, OP_IN: dcnt_reg <= dcnt_reg + 1'b1;
                        OP_POP:
                        begin
                            dcnt_reg <= dcnt_reg - 1'b1;
                            if (!um_reg && ur_reg)
                            begin
                                gr_reg[ri_reg] <= top_reg;
                            end
                        end
                        OP_OUT, OP_ADD, OP_SUB, OP_MUL, OP_DIV: dcnt_reg <= dcnt_reg - 1'b1;
                        OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE:
                            dcnt_reg <= dcnt_reg - 2'd2;
                        OP_CALL: rcnt_reg <= rcnt_reg + 1'b1;
                        OP_RET:  rcnt_reg <= rcnt_reg - 1'b1;
                        default: ;
                    endcase
                    if (kind_reg != OP_HALT)
                    begin
                        ip_reg <= nip_calc;
                    end
                end
            end
        end
    end

    always_comb
    begin
        case (kind_reg)
            OP_CALL, OP_JMP: nip_calc = tgt_reg;
            OP_RET: nip_calc = rs_rdata;
            OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE: nip_calc = take ? tgt_reg : seq_ip;
            default: nip_calc = seq_ip;
        endcase
    end

    // The register index wraps at the register count.
    logic [1:0] ri_in;
    always_comb
    begin
        ri_in = s_axis_tdata[41:40];
        for (int k = 0; k < 3; k++)
        begin
            if (REGISTER_COUNT < 4 && ri_in >= 2'(REGISTER_COUNT))
            begin
                ri_in = ri_in - 2'(REGISTER_COUNT);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            kind_reg <= s_axis_tdata[4:0];
            ui_reg <= s_axis_tdata[5];
            ur_reg <= s_axis_tdata[6];
            um_reg <= s_axis_tdata[7];
            imm_reg <= s_axis_tdata[39:8];
            ri_reg <= GRW'(ri_in);
            tgt_reg <= s_axis_tdata[57:42];
            con_reg <= s_axis_tdata[89:58];
        end
        if (state_reg == S_READ)
        begin
            top_reg <= ds_rdata;
            below_reg <= ds_rdata2;
            acc_reg <= prod;
        end
        if (state_reg == S_FINISH)
        begin
            ovld_reg <= 1'b0;
            oval_reg <= '0;
            nip_reg <= ip_reg;
            if (stopped_reg)
            begin
                st_reg <= (ip_reg >= plen_reg) ? ST_END : ST_HALTED;
            end
            else if (ip_reg >= plen_reg)
            begin
                st_reg <= ST_END;
            end
            else if (is_illegal)
            begin
                st_reg <= ST_ILLEGAL;
            end
            else if (is_stack_fault)
            begin
                st_reg <= ST_STACK;
            end
            else if (kind_reg == OP_DIV && top_reg == 32'd0)
            begin
                st_reg <= ST_DIVZERO;
            end
            else if (kind_reg == OP_HALT)
            begin
                st_reg <= ST_HALTED;
            end
            else
            begin
                st_reg <= ST_OK;
                nip_reg <= nip_calc;
                if (kind_reg == OP_OUT)
                begin
                    ovld_reg <= 1'b1;
                    oval_reg <= top_reg;
                end
            end
        end
    end

    unused_in_ip_chk: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> in_ip == ip_reg) else $error("ip copy mismatch");
    dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= (DAW+1)'(DATA_STACK_DEPTH)) else $error("data stack count overrun");
    rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= (RAW+1)'(RETURN_STACK_DEPTH)) else $error("return stack count overrun");
    no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready) else $error("accept during clear");
    stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(stopped_reg) |-> stopped_reg) else $error("stopped flag dropped");
endmodule

[tb/tb.sv]
// Self-checking testbench for stack_machine_execute: directed and random instruction
// words against a local fixed-point stack machine predictor. Depends on sme_pkg and stack_machine_execute.
`timescale 1ns / 100ps

module tb;
    import sme_pkg::*;

    localparam int          LIMIT         = 600000;
    localparam logic [4:0]  FIRST_ILLEGAL = 5'd20;
    localparam logic [4:0]  LAST_ILLEGAL  = 5'd31;
    localparam int          STACK_DEPTH   = 64;
    localparam int          RSTACK_DEPTH  = 16;
    localparam int          MEM_WORDS     = 1024;

    typedef struct {
        logic [4:0]         kind;
        bit                 ui;
        bit                 ur;
        bit                 um;
        logic signed [31:0] imm;
        logic [1:0]         ri;
        logic [15:0]        tgt;
        logic signed [31:0] con;
    } instr_t;

    typedef struct {
        status_t     status;
        logic [15:0] nip;
        bit          ovalid;
        logic [31:0] oval;
    } outcome_t;

    class machine_scoreboard;
        logic [15:0]        plen = 16'hFFFF;
        logic [9:0]         scale = 10'd100;
        logic [3:0]         obytes = 4'd1;
        logic [3:0]         vbytes = 4'd4;
        logic [15:0]        ip;
        logic signed [31:0] stack [STACK_DEPTH];
        int                 cnt;
        logic [15:0]        rstack [RSTACK_DEPTH];
        int                 rcnt;
        logic signed [31:0] regs [4];
        logic signed [31:0] mem [MEM_WORDS];
        bit                 stopped;
        outcome_t           pending_q [$];
        int                 fails;

        function new();
            ip = 0;
            cnt = 0;
            rcnt = 0;
            stopped = 0;
            fails = 0;
            foreach (regs[i]) regs[i] = 0;
            foreach (mem[i]) mem[i] = 0;
        endfunction

        function longint unsigned floor_root(longint unsigned x);
            longint unsigned root;
            longint unsigned c;
            root = 0;
            for (int b = 31; b >= 0; b--)
            begin
                c = root | (64'd1 << b);
                if (c * c <= x) root = c;
            end
            return root;
        endfunction

        function void note(instr_t w);
            outcome_t    r;
            longint      sc, immv, regv, top, below, res;
            logic [15:0] seq, nip;
            logic [31:0] addr32;
            int          addr;
            bit          take;
            r.status = ST_OK;
            r.ovalid = 0;
            r.oval = 0;
            if (stopped)
            begin
                r.status = (ip >= plen) ? ST_END : ST_HALTED;
            end
            else if (ip >= plen)
            begin
                stopped = 1;
                r.status = ST_END;
            end
            else
            begin
                nip = ip;
                seq = ip + obytes + (w.ui ? vbytes : 4'd0) + (w.ur ? obytes : 4'd0);
                sc = (scale == 0) ? 1 : longint'(scale);
                immv = w.ui ? longint'(w.imm) : 0;
                regv = w.ur ? longint'(regs[w.ri]) : 0;
                addr32 = 32'(immv + regv);
                addr = addr32 % MEM_WORDS;
                case (w.kind)
                    OP_HALT:
                    begin
                        stopped = 1;
                        r.status = ST_HALTED;
                    end
                    OP_PUSH, OP_IN:
                    begin
                        if (cnt >= STACK_DEPTH) r.status = ST_STACK;
                        else
                        begin
                            if (w.kind == OP_IN) stack[cnt] = 32'(longint'(w.con) * sc);
                            else if (w.um) stack[cnt] = mem[addr];
                            else stack[cnt] = 32'(immv * sc + regv);
                            cnt++;
                            nip = seq;
                        end
                    end
                    OP_POP:
                    begin
                        if ((w.ui && w.ur) || (w.ui && !w.um)) r.status = ST_ILLEGAL;
                        else if (cnt < 1) r.status = ST_STACK;
                        else
                        begin
                            if (w.um) mem[addr] = stack[cnt - 1];
                            else if (w.ur) regs[w.ri] = stack[cnt - 1];
                            cnt--;
                            nip = seq;
                        end
                    end
                    OP_OUT:
                    begin
                        if (cnt < 1) r.status = ST_STACK;
                        else
                        begin
                            r.ovalid = 1;
                            r.oval = stack[cnt - 1];
                            cnt--;
                            nip = seq;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (cnt < 2) r.status = ST_STACK;
                        else
                        begin
                            top = stack[cnt - 1];
                            below = stack[cnt - 2];
                            if (w.kind == OP_DIV && top == 0) r.status = ST_DIVZERO;
                            else
                            begin
                                case (w.kind)
                                    OP_ADD:  res = below + top;
                                    OP_SUB:  res = below - top;
                                    OP_MUL:  res = (top * below) / sc;
                                    default: res = (below * sc) / top;
                                endcase
                                cnt--;
                                stack[cnt - 1] = 32'(res);
                                nip = seq;
                            end
                        end
                    end
                    OP_SQRT, OP_SQR:
                    begin
                        if (cnt < 1) r.status = ST_STACK;
                        else
                        begin
                            top = stack[cnt - 1];
                            if (w.kind == OP_SQRT)
                                res = (top < 0) ? 0 : longint'(floor_root(top * sc));
                            else
                                res = (top * top) / sc;
                            stack[cnt - 1] = 32'(res);
                            nip = seq;
                        end
                    end
                    OP_CALL:
                    begin
                        if (rcnt >= RSTACK_DEPTH) r.status = ST_STACK;
                        else
                        begin
                            rstack[rcnt] = ip + obytes + vbytes;
                            rcnt++;
                            nip = w.tgt;
                        end
                    end
                    OP_RET:
                    begin
                        if (rcnt < 1) r.status = ST_STACK;
                        else
                        begin
                            rcnt--;
                            nip = rstack[rcnt];
                        end
                    end
                    OP_JMP: nip = w.tgt;
                    OP_JA, OP_JAE, OP_JB, OP_JBE, OP_JE, OP_JNE:
                    begin
                        if (cnt < 2) r.status = ST_STACK;
                        else
                        begin
                            top = stack[cnt - 1];
                            below = stack[cnt - 2];
                            case (w.kind)
                                OP_JA:   take = top > below;
                                OP_JAE:  take = top >= below;
                                OP_JB:   take = top < below;
                                OP_JBE:  take = top <= below;
                                OP_JE:   take = top == below;
                                default: take = top != below;
                            endcase
                            cnt -= 2;
                            nip = take ? w.tgt : seq;
                        end
                    end
                    default: r.status = ST_ILLEGAL;
                endcase
                ip = nip;
            end
            r.nip = ip;
            pending_q.push_back(r);
        endfunction

        task report(string s);
            $display("mismatch: %s", s);
            fails++;
        endtask

        task check(logic [55:0] d);
            outcome_t e;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected word %h", d));
                return;
            end
            e = pending_q.pop_front();
            if (d[2:0] != e.status)
                report($sformatf("status %0d, want %0d", d[2:0], e.status));
            if (d[18:3] != e.nip)
                report($sformatf("next_ip %0d, want %0d", d[18:3], e.nip));
            if (d[19] != e.ovalid)
                report($sformatf("out_valid %0b, want %0b", d[19], e.ovalid));
            if (d[51:20] != e.oval)
                report($sformatf("out_value %h, want %h", d[51:20], e.oval));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    machine_scoreboard sb = new();
    bit                calm = 0;
    int                cycles = 0;

    stack_machine_execute dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end

    function automatic instr_t mk(logic [4:0] kind, bit ui, bit ur, bit um,
                                  logic [31:0] imm, logic [1:0] ri,
                                  logic [15:0] tgt, logic [31:0] con);
        instr_t w;
        w.kind = kind;
        w.ui = ui;
        w.ur = ur;
        w.um = um;
        w.imm = imm;
        w.ri = ri;
        w.tgt = tgt;
        w.con = con;
        return w;
    endfunction

    function automatic logic [31:0] rand_value();
        return $urandom_range(0, 1) ? $urandom_range(0, 2000) - 1000 : $urandom;
    endfunction

    function automatic instr_t rand_word(logic [4:0] kind);
        return mk(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), rand_value(), 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 59999)), rand_value());
    endfunction

    function automatic instr_t pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (sb.ip > 16'd65000)
            return mk(OP_JMP, 0, 0, 0, 0, 0, 16'($urandom_range(0, 4000)), 0);
        if (r < 4)
            return rand_word(5'($urandom_range(FIRST_ILLEGAL, LAST_ILLEGAL)));
        if (sb.cnt < 2 && r < 60)
            return rand_word(r[0] ? OP_PUSH : OP_IN);
        return rand_word(5'($urandom_range(OP_PUSH, OP_JNE)));
    endfunction

    task send(instr_t w);
        if (!calm && $urandom_range(0, 99) < 24)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'b0, w.con, w.tgt, w.ri, w.imm, w.um, w.ur, w.ui, w.kind};
        do @(posedge clk); while (!s_axis_tready);
        sb.note(w);
    endtask

    task wait_idle();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task cfg_write(int idx, logic [31:0] val);
        psel <= 1;
        pwrite <= 1;
        paddr <= 4'(idx * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_PROGRAM_LENGTH: sb.plen = val[15:0];
            REG_SCALE:          sb.scale = val[9:0];
            REG_OPCODE_BYTES:   sb.obytes = val[3:0];
            default:            sb.vbytes = val[3:0];
        endcase
        @(posedge clk);
    endtask

    task set_config(int scale, int ob, int vb);
        cfg_write(REG_SCALE, scale);
        cfg_write(REG_OPCODE_BYTES, ob);
        cfg_write(REG_VALUE_BYTES, vb);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        cfg_write(REG_PROGRAM_LENGTH, 32'hFFFF);
        set_config(100, 1, 4);

        send(mk(OP_PUSH, 1, 0, 0, 32'h7FFFFFFF, 0, 0, 0));
        send(mk(OP_PUSH, 1, 0, 0, 32'h80000000, 0, 0, 0));
        send(mk(OP_ADD, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_IN, 0, 0, 0, 0, 0, 0, 32'h80000000));
        send(mk(OP_IN, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF));
        send(mk(OP_MUL, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_POP, 0, 1, 0, 0, 3, 0, 0));
        send(mk(OP_PUSH, 1, 1, 0, 5, 3, 0, 0));
        send(mk(OP_POP, 1, 0, 1, 1023, 0, 0, 0));
        send(mk(OP_PUSH, 1, 0, 1, 1023, 0, 0, 0));
        send(mk(OP_POP, 1, 1, 0, 0, 1, 0, 0));
        send(mk(OP_POP, 1, 0, 0, 0, 0, 0, 0));
        send(mk(OP_PUSH, 1, 0, 0, 0, 0, 0, 0));
        send(mk(OP_DIV, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_POP, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_PUSH, 1, 0, 0, -3, 0, 0, 0));
        send(mk(OP_SQRT, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_SQR, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_SUB, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_OUT, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_CALL, 1, 0, 0, 0, 0, 200, 0));
        send(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_RET, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_JMP, 1, 0, 0, 0, 0, 300, 0));
        send(mk(LAST_ILLEGAL, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_PUSH, 1, 0, 0, 7, 0, 0, 0));
        send(mk(OP_PUSH, 1, 0, 0, 7, 0, 0, 0));
        send(mk(OP_JE, 1, 0, 0, 0, 0, 400, 0));
        send(mk(OP_ADD, 0, 0, 0, 0, 0, 0, 0));

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_idle();
            case (phase)
                0:       set_config(1, 8, 8);
                1:       set_config(1000, 1, 1);
                default: set_config($urandom_range(1, 1000), $urandom_range(1, 8),
                                    $urandom_range(1, 8));
            endcase
            for (int k = 0; k < 130; k++)
            begin
                calm = (phase == 1 && k < 40);
                if (k == 30)
                    repeat (66) send(rand_word(OP_PUSH));
                else if (k == 60)
                begin
                    repeat (18) send(rand_word(OP_CALL));
                    repeat (18) send(rand_word(OP_RET));
                end
                else if (k == 80)
                    repeat (66) send(rand_word(OP_OUT));
                else if (k == 110)
                    wait_idle();
                send(pick_word());
            end
        end
        calm = 0;

        wait_idle();
        send(mk(OP_HALT, 0, 0, 0, 0, 0, 0, 0));
        repeat (2) send(pick_word());
        wait_idle();
        cfg_write(REG_PROGRAM_LENGTH, 0);
        repeat (2) send(pick_word());
        wait_idle();
        repeat (100) @(posedge clk);
        if (sb.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
